// File: rtl/scq_pkg.sv
package scq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int TAG_W     = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int IN_W      = OP_W + KEY_W + TAG_W + 1;
	localparam int IN_TW     = ((IN_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
	localparam logic [OP_W-1:0] OP_SET    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             flag;
	} entry_t;

	typedef struct packed {
		logic rotate;
		logic load;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} state_t;

endpackage

// File: rtl/scq_cell.sv
module scq_cell (
	input  logic                clk,
	input  scq_pkg::cell_ctrl_t ctl,
	input  scq_pkg::entry_t     nxt,
	input  scq_pkg::entry_t     wr,
	output scq_pkg::entry_t     ent
);

	scq_pkg::entry_t ent_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ent_q <= wr;
		end else if (ctl.rotate) begin
			ent_q <= nxt;
		end
	end

	assign ent = ent_q;

endmodule

// File: rtl/searchable_circular_queue.sv
// Push, pop, clear and unused codes: result registered when the transaction is taken.
// Lookup and set expanded: the sequencer steps through its search state and then its done
// state, where the result is registered; during the search the entry ring rotates once, one
// cell per cycle, past the single key comparator at the front cell.
// One operation at a time; the next transaction is taken once the result is out or leaving.
// arst_n clears the entry count, the sequencer and the output valid; entry contents are kept.
module searchable_circular_queue #(
	parameter int DEPTH = scq_pkg::DEPTH_DEF,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int OUT_W = scq_pkg::STATUS_W + scq_pkg::TAG_W + 1 + CW + scq_pkg::KEY_W,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// operation, key_value, tag_in, expanded_in
	input  logic [scq_pkg::IN_TW-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status, found_tag, found_expanded, entry_count, front_key
	output logic [OUT_TW-1:0]         m_tdata
);

	localparam int IW = $clog2(DEPTH);

	logic [scq_pkg::OP_W-1:0]  op_in;
	logic [scq_pkg::KEY_W-1:0] key_in;
	logic [scq_pkg::TAG_W-1:0] tag_in;
	logic                      exp_in;

	assign op_in  = s_tdata[scq_pkg::OP_W-1:0];
	assign key_in = s_tdata[scq_pkg::OP_W +: scq_pkg::KEY_W];
	assign tag_in = s_tdata[scq_pkg::OP_W + scq_pkg::KEY_W +: scq_pkg::TAG_W];
	assign exp_in = s_tdata[scq_pkg::OP_W + scq_pkg::KEY_W + scq_pkg::TAG_W];

	scq_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [IW-1:0]   k_q;
	logic            found_q;
	logic            set_q;
	logic            nflag_q;
	logic [scq_pkg::KEY_W-1:0] skey_q;
	logic [scq_pkg::TAG_W-1:0] ftag_q;
	logic            fflag_q;
	logic            m_tvalid_q;
	logic [OUT_TW-1:0] m_data_q;

	scq_pkg::entry_t    cells [DEPTH];
	scq_pkg::entry_t    ring  [DEPTH];
	scq_pkg::cell_ctrl_t ctl  [DEPTH];
	scq_pkg::entry_t    wr_e;
	scq_pkg::entry_t    fb;

	logic acc;
	logic rot;
	logic push_go;
	logic hit;
	logic out_load;
	logic [scq_pkg::STATUS_W-1:0] o_status;
	logic [scq_pkg::TAG_W-1:0]    o_tag;
	logic                         o_flag;
	logic [scq_pkg::KEY_W-1:0]    o_front;

	assign s_tready = (state_q == scq_pkg::S_IDLE) && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	assign wr_e.key  = key_in;
	assign wr_e.tag  = tag_in;
	assign wr_e.flag = exp_in;

	assign hit = (state_q == scq_pkg::S_SEARCH) && !found_q && (CW'(k_q) < cnt_q)
		&& (cells[0].key == skey_q);

	always_comb begin
		fb = cells[0];
		if (hit && set_q) begin
			fb.flag = nflag_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i < DEPTH - 1) begin : g_mid
			assign ring[i] = cells[i + 1];
		end else begin : g_last
			assign ring[i] = fb;
		end
		assign ctl[i].rotate = rot;
		assign ctl[i].load   = push_go && (cnt_q == CW'(i));
		scq_cell u_cell (
			.clk (clk),
			.ctl (ctl[i]),
			.nxt (ring[i]),
			.wr  (wr_e),
			.ent (cells[i])
		);
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rot      = 1'b0;
		push_go  = 1'b0;
		out_load = 1'b0;
		o_status = scq_pkg::ST_OK;
		o_tag    = '0;
		o_flag   = 1'b0;
		o_front  = (cnt_q != '0) ? cells[0].key : '0;
		unique case (state_q)
			scq_pkg::S_IDLE: begin
				if (acc) begin
					unique case (op_in)
						scq_pkg::OP_PUSH: begin
							out_load = 1'b1;
							if (cnt_q == CW'(DEPTH)) begin
								o_status = scq_pkg::ST_FULL;
							end else begin
								push_go = 1'b1;
								cnt_d   = cnt_q + 1'b1;
								if (cnt_q == '0) begin
									o_front = key_in;
								end
							end
						end
						scq_pkg::OP_POP: begin
							out_load = 1'b1;
							if (cnt_q == '0) begin
								o_status = scq_pkg::ST_EMPTY;
							end else begin
								rot     = 1'b1;
								cnt_d   = cnt_q - 1'b1;
								o_front = (cnt_q > CW'(1)) ? cells[1].key : '0;
							end
						end
						scq_pkg::OP_CLEAR: begin
							out_load = 1'b1;
							cnt_d    = '0;
							o_front  = '0;
						end
						scq_pkg::OP_LOOKUP, scq_pkg::OP_SET: begin
							state_d = scq_pkg::S_SEARCH;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			scq_pkg::S_SEARCH: begin
				rot = 1'b1;
				if (k_q == IW'(DEPTH - 1)) begin
					state_d = scq_pkg::S_DONE;
				end
			end
			scq_pkg::S_DONE: begin
				out_load = 1'b1;
				state_d  = scq_pkg::S_IDLE;
				o_status = found_q ? scq_pkg::ST_OK : scq_pkg::ST_MISSING;
				if (found_q && !set_q) begin
					o_tag  = ftag_q;
					o_flag = fflag_q;
				end
			end
			default: begin
				state_d = scq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= scq_pkg::S_IDLE;
			cnt_q      <= '0;
			k_q        <= '0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (acc) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end else if (state_q == scq_pkg::S_SEARCH) begin
				k_q <= k_q + 1'b1;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			skey_q  <= key_in;
			set_q   <= (op_in == scq_pkg::OP_SET);
			nflag_q <= exp_in;
		end
		if (hit) begin
			ftag_q  <= cells[0].tag;
			fflag_q <= cells[0].flag;
		end
		if (out_load) begin
			m_data_q <= OUT_TW'({o_front, cnt_d, o_flag, o_tag, o_status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: sim/searchable_circular_queue_tb.sv
`default_nettype none

module searchable_circular_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scq_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int AW         = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int OUT_W      = STATUS_W + TAG_W + 1 + CNT_W + KEY_W;
	localparam int OUT_TW     = ((OUT_W + 7) / 8) * 8;
	localparam int DIR_ROWS   = 23;
	localparam int RAND_ITEMS = 1327;
	localparam int ALL_ITEMS  = DIR_ROWS + RAND_ITEMS;
	localparam int QUIET_TAIL = 150;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 400;
	localparam int CYCLE_CAP  = 500000;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

	localparam int MODE_MIX    = 0;
	localparam int MODE_FILL   = 1;
	localparam int MODE_DRAIN  = 2;
	localparam int MODE_SEARCH = 3;

	typedef struct packed {
		logic             flag;
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
		logic [OP_W-1:0]  op;
	} queue_cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0]    front;
		logic [CNT_W-1:0]    count;
		logic                fflag;
		logic [TAG_W-1:0]    ftag;
		logic [STATUS_W-1:0] status;
	} queue_reply_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [KEY_W-1:0]    key;
		logic [TAG_W-1:0]    tag;
		logic                flag;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    ftag;
		logic                fflag;
		logic [CNT_W-1:0]    count;
		logic [KEY_W-1:0]    front;
	} dir_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_TW-1:0]    s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TW-1:0]   m_tdata;

	logic [KEY_W-1:0]    key_mem  [DEPTH];
	logic [TAG_W-1:0]    tag_mem  [DEPTH];
	logic                flag_mem [DEPTH];
	logic [AW-1:0]       head_slot = '0;
	logic [CNT_W-1:0]    held      = '0;

	queue_reply_t        expected_replies [$];
	queue_reply_t        got_reply;
	queue_reply_t        want_reply;
	int                  accepted_count = 0;
	int                  mismatches     = 0;
	int                  cycles         = 0;
	bit                  gaps_on        = 1'b1;
	bit                  hold_done      = 1'b0;
	logic                quiet;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{OP_POP,     32'h0,        32'h0,        1'b0, 1'b1, ST_EMPTY,   32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_LOOKUP,  32'h0,        32'h0,        1'b0, 1'b1, ST_MISSING, 32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_SET,     32'hFFFFFFFF, 32'h0,        1'b1, 1'b1, ST_MISSING, 32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_SPARE_C, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_PUSH,    32'hFFFFFFFF, 32'h0,        1'b1, 1'b1, ST_OK,      32'h0, 1'b0, 5'd1,
			32'hFFFFFFFF},
		'{OP_PUSH,    32'h0,        32'hFFFFFFFF, 1'b0, 1'b1, ST_OK,      32'h0, 1'b0, 5'd2,
			32'hFFFFFFFF},
		'{OP_PUSH,    32'hFFFFFFFF, 32'hA5A5A5A5, 1'b0, 1'b1, ST_OK,      32'h0, 1'b0, 5'd3,
			32'hFFFFFFFF},
		'{OP_LOOKUP,  32'hFFFFFFFF, 32'h0,        1'b0, 1'b1, ST_OK,      32'h0, 1'b1, 5'd3,
			32'hFFFFFFFF},
		'{OP_SET,     32'hFFFFFFFF, 32'h0,        1'b0, 1'b1, ST_OK,      32'h0, 1'b0, 5'd3,
			32'hFFFFFFFF},
		'{OP_LOOKUP,  32'hFFFFFFFF, 32'h0,        1'b1, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_LOOKUP,  32'h0,        32'h0,        1'b0, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_LOOKUP,  32'h12345678, 32'h0,        1'b0, 1'b1, ST_MISSING, 32'h0, 1'b0, 5'd3,
			32'hFFFFFFFF},
		'{OP_POP,     32'h0,        32'h0,        1'b0, 1'b1, ST_OK,      32'h0, 1'b0, 5'd2, 32'h0},
		'{OP_LOOKUP,  32'hFFFFFFFF, 32'h0,        1'b0, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_SPARE_A, 32'h55AA55AA, 32'hFFFFFFFF, 1'b1, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_SPARE_B, 32'h0,        32'h0,        1'b0, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_SET,     32'h0,        32'h0,        1'b1, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_LOOKUP,  32'h0,        32'h0,        1'b0, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_CLEAR,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_POP,     32'h0,        32'h0,        1'b0, 1'b1, ST_EMPTY,   32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_PUSH,    32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1, ST_OK,      32'h0, 1'b0, 5'd1,
			32'h80000000},
		'{OP_LOOKUP,  32'h80000000, 32'h0,        1'b0, 1'b0, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0},
		'{OP_POP,     32'h0,        32'h0,        1'b0, 1'b1, ST_OK,      32'h0, 1'b0, 5'd0, 32'h0}
	};

	searchable_circular_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign quiet = (accepted_count >= ALL_ITEMS - QUIET_TAIL);

	task automatic apply_queue_op(input queue_cmd_t cmd, output queue_reply_t r);
		logic [AW-1:0] slot;
		logic [AW-1:0] probe;
		logic          hit;
		int            i;
		r    = '0;
		hit  = 1'b0;
		slot = '0;
		if (cmd.op == OP_LOOKUP || cmd.op == OP_SET) begin
			for (i = 0; i < held; i++) begin
				probe = head_slot + AW'(i);
				if (!hit && key_mem[probe] == cmd.key) begin
					hit  = 1'b1;
					slot = probe;
				end
			end
		end
		case (cmd.op)
			OP_PUSH: begin
				if (held >= CNT_W'(DEPTH)) begin
					r.status = ST_FULL;
				end else begin
					slot           = head_slot + AW'(held);
					key_mem[slot]  = cmd.key;
					tag_mem[slot]  = cmd.tag;
					flag_mem[slot] = cmd.flag;
					held           = held + 1'b1;
				end
			end
			OP_POP: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					head_slot = head_slot + 1'b1;
					held      = held - 1'b1;
				end
			end
			OP_CLEAR: begin
				head_slot = '0;
				held      = '0;
			end
			OP_LOOKUP: begin
				if (hit) begin
					r.ftag  = tag_mem[slot];
					r.fflag = flag_mem[slot];
				end else begin
					r.status = ST_MISSING;
				end
			end
			OP_SET: begin
				if (hit)
					flag_mem[slot] = cmd.flag;
				else
					r.status = ST_MISSING;
			end
			default: begin
			end
		endcase
		r.status = r.status;
		r.count  = held;
		r.front  = (held != 0) ? key_mem[head_slot] : '0;
	endtask

	function automatic logic [KEY_W-1:0] pool_key();
		case ($urandom_range(0, 5))
			0:       return 32'h0;
			1:       return 32'hFFFFFFFF;
			2:       return 32'h1;
			3:       return 32'h80000000;
			4:       return 32'h7FFFFFFF;
			default: return 32'hDEADBEEF;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] search_key();
		int r;
		r = $urandom_range(0, 9);
		if (held != 0 && r < 6)
			return key_mem[head_slot + AW'($urandom_range(0, held - 1))];
		else if (r < 8)
			return pool_key();
		else
			return $urandom;
	endfunction

	function automatic queue_cmd_t make_cmd(input int mode);
		queue_cmd_t cmd;
		int         r;
		int         t_push, t_pop, t_look, t_set, t_clr;
		case (mode)
			MODE_FILL:   begin t_push = 65; t_pop = 73; t_look = 85; t_set = 95; t_clr = 96; end
			MODE_DRAIN:  begin t_push = 15; t_pop = 60; t_look = 78; t_set = 94; t_clr = 96; end
			MODE_SEARCH: begin t_push = 20; t_pop = 30; t_look = 65; t_set = 95; t_clr = 97; end
			default:     begin t_push = 30; t_pop = 52; t_look = 74; t_set = 92; t_clr = 95; end
		endcase
		r        = $urandom_range(0, 99);
		cmd.flag = 1'($urandom_range(0, 1));
		cmd.tag  = ($urandom_range(0, 9) == 0) ? pool_key() : $urandom;
		cmd.key  = $urandom;
		if (r < t_push) begin
			cmd.op = OP_PUSH;
			if ($urandom_range(0, 9) < 4)
				cmd.key = pool_key();
		end else if (r < t_pop) begin
			cmd.op = OP_POP;
		end else if (r < t_look) begin
			cmd.op  = OP_LOOKUP;
			cmd.key = search_key();
		end else if (r < t_set) begin
			cmd.op  = OP_SET;
			cmd.key = search_key();
		end else if (r < t_clr) begin
			cmd.op = OP_CLEAR;
		end else begin
			cmd.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
		end
		return cmd;
	endfunction

	task automatic send_cmd(input queue_cmd_t cmd, input bit typed, input queue_reply_t fixed);
		queue_reply_t predicted;
		if (gaps_on && !quiet && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TW - IN_W){1'b0}}, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		apply_queue_op(cmd, predicted);
		expected_replies.push_back(typed ? fixed : predicted);
		accepted_count++;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_reply = m_tdata[OUT_W-1:0];
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual %h", $time, got_reply);
				mismatches++;
			end else begin
				want_reply = expected_replies.pop_front();
				check_field("status",         32'(want_reply.status), 32'(got_reply.status));
				check_field("found_tag",      want_reply.ftag,        got_reply.ftag);
				check_field("found_expanded", 32'(want_reply.fflag),  32'(got_reply.fflag));
				check_field("entry_count",    32'(want_reply.count),  32'(got_reply.count));
				check_field("front_key",      want_reply.front,       got_reply.front);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int hold_cycles;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			if (!hold_done && accepted_count >= HOLD_AT) begin
				m_tready    <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < HOLD_LEN) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		queue_cmd_t   cmd;
		queue_reply_t fixed;
		int           n;
		int           phase_left;
		int           mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			cmd.op       = directed_rows[i].op;
			cmd.key      = directed_rows[i].key;
			cmd.tag      = directed_rows[i].tag;
			cmd.flag     = directed_rows[i].flag;
			fixed.status = directed_rows[i].status;
			fixed.ftag   = directed_rows[i].ftag;
			fixed.fflag  = directed_rows[i].fflag;
			fixed.count  = directed_rows[i].count;
			fixed.front  = directed_rows[i].front;
			send_cmd(cmd, directed_rows[i].typed, fixed);
		end

		phase_left = 0;
		mode       = MODE_MIX;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(30, 90);
				mode       = $urandom_range(MODE_MIX, MODE_SEARCH);
				gaps_on    = ($urandom_range(0, 3) != 0);
			end
			cmd = make_cmd(mode);
			send_cmd(cmd, 1'b0, '0);
			phase_left--;
		end
		s_tvalid <= 1'b0;

		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
